@@ hdl/kab_pkg.sv @@
// Shared types and constants for the k-th ancestor block.
`timescale 1ns / 1ps
package kab_pkg;

  localparam int CMD_W = 2;
  localparam int ID_W = 10;
  localparam int K_W = 10;

  localparam int NODES_DEF = 1024;
  localparam int LEVELS_DEF = 10;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic valid;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_BRD0,
    S_BRD1,
    S_BWR,
    S_QRD,
    S_QAP,
    S_QOUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_wr;
    logic bld_start;
    logic bld_rd_self;
    logic bld_rd_mid;
    logic bld_wr;
    logic q_start;
    logic q_rd;
    logic q_apply;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic bld_skip;
    logic bld_last;
    logic q_more;
  } stat_t;

endpackage

@@ hdl/kab_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kab_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/kab_ctrl.sv @@
// Controller state machine for the k-th ancestor block.
`timescale 1ns / 1ps
module kab_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kab_pkg::CMD_W-1:0]   cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  kab_pkg::stat_t              stat,
  output kab_pkg::ctrl_t              ctrl
);
  import kab_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;
  logic   out_free;

  assign take = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR: begin
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_BUILD: begin
              if (!stat.bld_skip) begin
                state_next = S_BRD0;
              end
            end
            CMD_QUERY: state_next = S_QRD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_BRD0: state_next = S_BRD1;
      S_BRD1: state_next = S_BWR;
      S_BWR: begin
        state_next = stat.bld_last ? S_IDLE : S_BRD0;
      end
      S_QRD: begin
        state_next = stat.q_more ? S_QAP : S_QOUT;
      end
      S_QAP: state_next = S_QRD;
      S_QOUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    case (state)
      S_CLR: ctrl.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        ctrl.load_wr = take && (cmd == CMD_LOAD);
        ctrl.bld_start = take && (cmd == CMD_BUILD);
        ctrl.q_start = take && (cmd == CMD_QUERY);
      end
      S_BRD0: ctrl.bld_rd_self = 1'b1;
      S_BRD1: ctrl.bld_rd_mid = 1'b1;
      S_BWR: ctrl.bld_wr = 1'b1;
      S_QRD: ctrl.q_rd = stat.q_more;
      S_QAP: ctrl.q_apply = 1'b1;
      S_QOUT: ctrl.out_load = out_free;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an item not yet taken");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == CMD_QUERY) |=> !in_ready)
    else $error("new item taken while a query is in progress");

  a_build_no_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_BWR) |-> !ctrl.out_load)
    else $error("result produced during table build");

endmodule

@@ hdl/kab_dp.sv @@
// Datapath for the k-th ancestor block: jump table, build and query registers.
`timescale 1ns / 1ps
module kab_dp #(
  parameter int NODES = kab_pkg::NODES_DEF,
  parameter int LEVELS = kab_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kab_pkg::ctrl_t             ctrl,
  output kab_pkg::stat_t             stat,
  input  logic [kab_pkg::ID_W-1:0]   node_id,
  input  logic [kab_pkg::ID_W-1:0]   parent_id,
  input  logic                       has_parent,
  input  logic [kab_pkg::K_W-1:0]    steps,
  output logic [kab_pkg::ID_W-1:0]   ancestor,
  output logic                       found
);
  import kab_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH = LEVELS * (2 ** NW);
  localparam int AW = $clog2(DEPTH);
  localparam int TOP = LEVELS - 1;
  localparam logic [K_W-1:0] LOW_MASK =
    (TOP >= K_W) ? '1 : K_W'((1 << TOP) - 1);

  logic [AW-1:0]    clr_addr;
  logic [LW-1:0]    bld_lvl;
  logic [NW-1:0]    bld_n;
  logic             mid_ok;
  logic [NW-1:0]    cur;
  logic             ok;
  logic [K_W-1:0]   high;
  logic [K_W-1:0]   low;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_ent;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [$bits(entry_t)-1:0] rd_raw;
  entry_t           rd_ent;

  logic             in_node_ok;
  logic             in_par_ok;
  logic [NW-1:0]    in_node;
  logic [LW-1:0]    msb_lvl;
  logic [LW-1:0]    jlvl;
  logic [LW-1:0]    bld_prev;

  assign rd_ent = entry_t'(rd_raw);
  assign in_node_ok = 32'(node_id) < 32'(NODES);
  assign in_par_ok = has_parent && (32'(parent_id) < 32'(NODES));
  assign in_node = NW'(node_id);
  assign bld_prev = LW'(bld_lvl - LW'(1));

  always_comb begin
    msb_lvl = '0;
    for (int i = 0; i < K_W; i++) begin
      if (low[i]) begin
        msb_lvl = LW'(i);
      end
    end
  end

  assign jlvl = (high != '0) ? LW'(TOP) : msb_lvl;

  assign stat.clr_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.bld_skip = (LEVELS == 1);
  assign stat.bld_last = (bld_n == NW'(NODES - 1)) && (bld_lvl == LW'(TOP));
  assign stat.q_more = ok && ((high != '0) || (low != '0));

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_ent = '0;
    if (ctrl.clr_step) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
    end else if (ctrl.load_wr) begin
      wr_en = in_node_ok;
      wr_addr = AW'(in_node);
      wr_ent.valid = in_par_ok;
      wr_ent.id = in_par_ok ? parent_id : '0;
    end else if (ctrl.bld_wr) begin
      wr_en = 1'b1;
      wr_addr = AW'({bld_lvl, bld_n});
      wr_ent = mid_ok ? rd_ent : '0;
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (ctrl.bld_rd_self) begin
      rd_en = 1'b1;
      rd_addr = AW'({bld_prev, bld_n});
    end else if (ctrl.bld_rd_mid) begin
      rd_en = 1'b1;
      rd_addr = AW'({bld_prev, NW'(rd_ent.id)});
    end else if (ctrl.q_rd) begin
      rd_en = 1'b1;
      rd_addr = AW'({jlvl, cur});
    end
  end

  kab_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_table (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clr_step && !stat.clr_last) begin
      clr_addr <= AW'(clr_addr + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bld_lvl <= LW'(1);
      bld_n <= '0;
    end else if (ctrl.bld_start) begin
      bld_lvl <= LW'(1);
      bld_n <= '0;
    end else if (ctrl.bld_wr) begin
      if (bld_n == NW'(NODES - 1)) begin
        bld_n <= '0;
        bld_lvl <= LW'(bld_lvl + LW'(1));
      end else begin
        bld_n <= NW'(bld_n + NW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bld_rd_mid) begin
      mid_ok <= rd_ent.valid && (32'(rd_ent.id) < 32'(NODES));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.q_start) begin
      cur <= in_node;
      ok <= in_node_ok;
      high <= steps >> TOP;
      low <= steps & LOW_MASK;
    end else if (ctrl.q_rd) begin
      if (high != '0) begin
        high <= K_W'(high - K_W'(1));
      end else begin
        low <= low & ~(K_W'(1) << msb_lvl);
      end
    end else if (ctrl.q_apply) begin
      ok <= rd_ent.valid;
      cur <= NW'(rd_ent.id);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      ancestor <= ok ? ID_W'(cur) : '0;
      found <= ok;
    end
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("table read and write at the same entry");

  a_id_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.q_apply && rd_ent.valid) |-> (32'(rd_ent.id) < 32'(NODES)))
    else $error("table entry holds a node out of range");

  a_build_above_base: assert property (@(posedge clk) disable iff (rst)
    ctrl.bld_wr |-> (bld_lvl != '0))
    else $error("build writes into the parent level");

endmodule

@@ hdl/kth_ancestor_binary_lifting.sv @@
// Top level of the k-th ancestor block: controller, datapath and jump table.
`timescale 1ns / 1ps
// Usage:
//   One input channel (in_valid/in_ready) carries an item with cmd, node_id,
//   parent_id, has_parent and steps. cmd load writes a node's parent, build
//   fills the jump table from its parent level, query climbs steps levels.
//   Only a query gives a result on the output channel (out_valid/out_ready):
//   ancestor and found. Other codes are taken and dropped.
//   After reset the table is swept to "no ancestor", one entry a cycle, all
//   LEVELS * 2**clog2(NODES) entries (10240 at the defaults); in_ready stays
//   low meanwhile.
//   A load is one table write. A build fills each node's entry at every level
//   above 0 with two table reads and one table write. A query with j jumps
//   (j = set bits of steps below LEVELS-1 plus steps >> (LEVELS-1)) holds
//   the input until its result is registered, each jump being a table read
//   followed by an apply step.
//   The result waits in an output register while the receiver stalls; loads
//   and builds go on meanwhile, and a later query waits for that register.
module kth_ancestor_binary_lifting #(
  parameter int NODES = kab_pkg::NODES_DEF,
  parameter int LEVELS = kab_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kab_pkg::CMD_W-1:0]  cmd,
  input  logic [kab_pkg::ID_W-1:0]   node_id,
  input  logic [kab_pkg::ID_W-1:0]   parent_id,
  input  logic                       has_parent,
  input  logic [kab_pkg::K_W-1:0]    steps,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kab_pkg::ID_W-1:0]   ancestor,
  output logic                       found
);
  import kab_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  kab_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat(stat),
    .ctrl(ctrl)
  );

  kab_dp #(
    .NODES(NODES),
    .LEVELS(LEVELS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .stat(stat),
    .node_id(node_id),
    .parent_id(parent_id),
    .has_parent(has_parent),
    .steps(steps),
    .ancestor(ancestor),
    .found(found)
  );

endmodule
